// ===== rtl/lrar_pkg.sv =====
`timescale 1ns / 1ps

package lrar_pkg;

	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = 32;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_RECORD_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MINIMUM_SEVERITY  = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RATE_INTERVAL_MS  = 2'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RATE_BURST        = 2'd3;

	localparam logic [15:0] MAX_RECORD_LENGTH_RESET = 16'hFFFF;
	localparam logic [4:0]  MINIMUM_SEVERITY_RESET  = 5'd1;

	localparam logic [1:0] OP_RECORD       = 2'd0;
	localparam logic [1:0] OP_TICK         = 2'd1;
	localparam logic [1:0] OP_NEW_PRODUCER = 2'd2;

	localparam logic [2:0] VERDICT_DELIVERED    = 3'd0;
	localparam logic [2:0] VERDICT_FILTERED     = 3'd1;
	localparam logic [2:0] VERDICT_RATE_LIMITED = 3'd2;
	localparam logic [2:0] VERDICT_TOO_LONG     = 3'd3;
	localparam logic [2:0] VERDICT_MALFORMED    = 3'd4;
	localparam logic [2:0] VERDICT_OUT_OF_ORDER = 3'd5;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] record_length;
		logic        well_formed;
		logic [31:0] sequence_number;
		logic [4:0]  severity;
	} rec_word_t;

	typedef struct packed {
		logic [2:0]  verdict;
		logic [31:0] accepted_count;
		logic [31:0] filtered_count;
		logic [31:0] limited_count;
		logic [31:0] limited_this_severity;
		logic [31:0] rejected_count;
		logic [31:0] newest_sequence;
	} res_word_t;

endpackage

// ===== rtl/lrar_word_if.sv =====
`timescale 1ns / 1ps

interface lrar_word_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/log_record_admission_rate_limiter.sv =====
`timescale 1ns / 1ps
// Log record admission with a fixed-window rate limiter.
// Words arrive on rec_in: a record, a millisecond tick or a new-producer marker.
// Each record yields exactly one result word on res_out carrying its verdict and
// the statistics counters after it; ticks and new-producer markers yield none.
// Registers are written through cfg_we, cfg_index and cfg_data, by the user only
// while the block is idle (the block itself does not enforce this); writing the
// interval or burst register restarts the rate window. A word taken on rec_in
// is held in an input register and is evaluated from there against the limiter
// state; a record's result lands in the output register, from which the
// receiver takes it. One word is accepted every cycle while rec_in.ready is
// high; the state update of one word is complete before the next is evaluated.
// When res_out stalls, the output register holds its word and one further word
// can still be taken into the input register; rec_in.ready drops only while
// both are occupied by records.
// Reset clears the counters, the window, the sequence tracking and both valid
// flags of the pipeline registers, and returns registers to their reset values.
module log_record_admission_rate_limiter
	import lrar_pkg::*;
#(
	parameter int SEVERITY_LEVELS = 24,
	parameter int COUNTER_WIDTH   = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
	lrar_word_if.sink                  rec_in,
	lrar_word_if.source                res_out
);

	localparam int LEVEL_IDX_W = (SEVERITY_LEVELS > 1) ? $clog2(SEVERITY_LEVELS) : 1;
	localparam logic [5:0] LEVEL_TOP = 6'(SEVERITY_LEVELS);

	logic                     valid_s1;
	rec_word_t                word_s1;
	logic                     out_valid_q;
	res_word_t                out_word_q;

	logic [15:0]              max_len_q;
	logic [4:0]               min_sev_q;
	logic [31:0]              interval_q;
	logic [31:0]              burst_q;

	logic [31:0]              last_seq_q;
	logic [31:0]              elapsed_q;
	logic [31:0]              used_q;
	logic [COUNTER_WIDTH-1:0] delivered_q;
	logic [COUNTER_WIDTH-1:0] filtered_q;
	logic [COUNTER_WIDTH-1:0] limited_q;
	logic [COUNTER_WIDTH-1:0] rejected_q;
	logic [COUNTER_WIDTH-1:0] level_q [SEVERITY_LEVELS];

	logic                     out_free;
	logic                     is_record;
	logic                     advance;

	logic                     level_ok;
	logic [LEVEL_IDX_W-1:0]   level_idx;
	logic [COUNTER_WIDTH-1:0] level_sel;
	logic [COUNTER_WIDTH-1:0] level_next;
	logic                     limit_on;
	logic                     window_expired;
	logic [31:0]              used_base;
	logic                     window_open;

	logic [2:0]               verdict;
	logic                     limited;
	logic [31:0]              nxt_last_seq;
	logic [31:0]              nxt_elapsed;
	logic [31:0]              nxt_used;
	logic [COUNTER_WIDTH-1:0] nxt_delivered;
	logic [COUNTER_WIDTH-1:0] nxt_filtered;
	logic [COUNTER_WIDTH-1:0] nxt_limited;
	logic [COUNTER_WIDTH-1:0] nxt_rejected;
	res_word_t                result;

	assign out_free      = !out_valid_q || res_out.ready;
	assign is_record     = (word_s1.operation == OP_RECORD);
	assign advance       = valid_s1 && (!is_record || out_free);
	assign rec_in.ready  = !valid_s1 || advance;
	assign res_out.valid = out_valid_q;
	assign res_out.data  = out_word_q;

	assign level_ok   = (word_s1.severity != 5'd0) && ({1'b0, word_s1.severity} <= LEVEL_TOP);
	assign level_idx  = LEVEL_IDX_W'(word_s1.severity - 5'd1);
	assign level_sel  = level_ok ? level_q[level_idx] : '0;
	assign level_next = level_sel + 1'b1;

	assign limit_on       = (interval_q != 32'd0);
	assign window_expired = (elapsed_q >= interval_q);
	assign used_base      = window_expired ? 32'd0 : used_q;
	assign window_open    = (used_base < burst_q);

	always_comb begin
		verdict       = VERDICT_DELIVERED;
		limited       = 1'b0;
		nxt_last_seq  = last_seq_q;
		nxt_elapsed   = elapsed_q;
		nxt_used      = used_q;
		nxt_delivered = delivered_q;
		nxt_filtered  = filtered_q;
		nxt_limited   = limited_q;
		nxt_rejected  = rejected_q;
		case (word_s1.operation)
			OP_TICK: begin
				if (elapsed_q != 32'hFFFF_FFFF) begin
					nxt_elapsed = elapsed_q + 32'd1;
				end
			end
			OP_NEW_PRODUCER: begin
				nxt_last_seq = 32'd0;
			end
			OP_RECORD: begin
				if (word_s1.record_length > max_len_q) begin
					verdict      = VERDICT_TOO_LONG;
					nxt_rejected = rejected_q + 1'b1;
				end else if (!word_s1.well_formed) begin
					verdict      = VERDICT_MALFORMED;
					nxt_rejected = rejected_q + 1'b1;
				end else if (word_s1.sequence_number <= last_seq_q) begin
					verdict      = VERDICT_OUT_OF_ORDER;
					nxt_rejected = rejected_q + 1'b1;
				end else if (word_s1.severity < min_sev_q) begin
					verdict      = VERDICT_FILTERED;
					nxt_filtered = filtered_q + 1'b1;
					nxt_last_seq = word_s1.sequence_number;
				end else begin
					nxt_last_seq = word_s1.sequence_number;
					if (limit_on) begin
						nxt_elapsed = window_expired ? 32'd0 : elapsed_q;
						nxt_used    = window_open ? used_base + 32'd1 : used_base;
						limited     = !window_open;
					end
					if (limited) begin
						verdict     = VERDICT_RATE_LIMITED;
						nxt_limited = limited_q + 1'b1;
					end else begin
						verdict       = VERDICT_DELIVERED;
						nxt_delivered = delivered_q + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		result.verdict               = verdict;
		result.accepted_count        = 32'(nxt_delivered);
		result.filtered_count        = 32'(nxt_filtered);
		result.limited_count         = 32'(nxt_limited);
		result.limited_this_severity = level_ok ? 32'(limited ? level_next : level_sel) : 32'd0;
		result.rejected_count        = 32'(nxt_rejected);
		result.newest_sequence       = nxt_last_seq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q   <= MAX_RECORD_LENGTH_RESET;
			min_sev_q   <= MINIMUM_SEVERITY_RESET;
			interval_q  <= '0;
			burst_q     <= '0;
			last_seq_q  <= '0;
			elapsed_q   <= '0;
			used_q      <= '0;
			delivered_q <= '0;
			filtered_q  <= '0;
			limited_q   <= '0;
			rejected_q  <= '0;
			for (int i = 0; i < SEVERITY_LEVELS; i++) begin
				level_q[i] <= '0;
			end
		end else begin
			if (advance) begin
				last_seq_q  <= nxt_last_seq;
				elapsed_q   <= nxt_elapsed;
				used_q      <= nxt_used;
				delivered_q <= nxt_delivered;
				filtered_q  <= nxt_filtered;
				limited_q   <= nxt_limited;
				rejected_q  <= nxt_rejected;
				if (limited && level_ok) begin
					level_q[level_idx] <= level_next;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_RECORD_LENGTH: begin
						max_len_q <= cfg_data[15:0];
					end
					REG_MINIMUM_SEVERITY: begin
						min_sev_q <= cfg_data[4:0];
					end
					REG_RATE_INTERVAL_MS: begin
						interval_q <= cfg_data;
						elapsed_q  <= '0;
						used_q     <= '0;
					end
					REG_RATE_BURST: begin
						burst_q   <= cfg_data;
						elapsed_q <= '0;
						used_q    <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rec_in.ready) begin
				valid_s1 <= rec_in.valid;
			end
			if (out_free) begin
				out_valid_q <= advance && is_record;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_in.valid && rec_in.ready) begin
			word_s1 <= rec_in.data;
		end
		if (advance && is_record) begin
			out_word_q <= result;
		end
	end

endmodule
